### src/utf8t_pkg.sv
package utf8t_pkg;

    // error kinds carried on results
    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_NULL  = 3'd1;
    localparam logic [2:0] ERR_LEAD  = 3'd2;
    localparam logic [2:0] ERR_TRAIL = 3'd3;
    localparam logic [2:0] ERR_TRUNC = 3'd4;
    localparam logic [2:0] ERR_ILLEG = 3'd5;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRICT_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REJECT_NULL = 1'd1;

    localparam int unsigned ACC_W = 31;

    localparam logic [15:0]      REPL_CHAR   = 16'hFFFD;
    localparam logic [ACC_W-1:0] BMP_MAX     = 31'h0000_FFFF;
    localparam logic [ACC_W-1:0] MAX_CODE    = 31'h0010_FFFF;
    localparam logic [15:0]      SURR_HI     = 16'hD800;
    localparam logic [15:0]      SURR_LO     = 16'hDC00;
    localparam logic [15:0]      SURR_END    = 16'hDFFF;
    localparam logic [15:0]      TEN_MASK    = 16'h03FF;
    localparam logic [20:0]      PLANE1_BASE = 21'h01_0000;

    // byte classes
    localparam logic [7:0] BYTE_ASCII_END = 8'h80;
    localparam logic [7:0] BYTE_LEAD_MIN  = 8'hC0;
    localparam logic [7:0] BYTE_LEAD_BIG  = 8'hFC;
    localparam logic [7:0] BYTE_LEAD_FD   = 8'hFD;

    typedef struct packed {
        logic [15:0] code_unit;
        logic [2:0]  error_kind;
        logic        out_last;
    } result_t;

    // what one decoded byte produces: up to two results
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } dec_t;

endpackage

### src/utf8t_byte_if.sv
interface utf8t_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

### src/utf8t_unit_if.sv
interface utf8t_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic [2:0]  error_kind;
    logic        out_last;

    modport source (output valid, output code_unit, output error_kind, output out_last,
                    input ready);
    modport sink   (input valid, input code_unit, input error_kind, input out_last,
                    output ready);
endinterface

### src/utf8t_cfg_if.sv
interface utf8t_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [utf8t_pkg::CFG_IDX_W-1:0] index;
    logic                             data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### src/utf8_to_utf16_transcoder_top.sv
// UTF-8 to UTF-16 transcoder.
// byte_in : one UTF-8 byte per transaction, in_last marks the message's last byte.
// unit_out: one UTF-16 code unit per transaction; error_kind != 0 marks the single
//           error transaction that closes a failed message (code_unit is zero).
//           out_last is set on the final transaction of each message.
// cfg     : register writes, index 0 strict_mode, index 1 reject_null; always ready.
//           Write only while no byte is in flight.
// Path    : an accepted byte passes the input register, then the 2-entry result
//           register, before it can leave unit_out.
// Rate    : one byte per cycle while unit_out.ready is high and each byte yields at
//           most one unit; a byte that completes a supplementary code point yields a
//           surrogate pair and waits for an empty 2-entry result register.
// Bytes that yield nothing (leads, dropped bytes after an error) pass at one per cycle.
// Reset   : clears decode state and both queues; strict_mode = 1, reject_null = 0.
// Stall   : when unit_out.ready is low the result register fills, then the input
//           register holds its byte and byte_in.ready drops. byte_in.ready does not
//           depend combinationally on unit_out.ready.
module utf8_to_utf16_transcoder_top (
    input  logic         clk,
    input  logic         rst_n,
    utf8t_byte_if.sink   byte_in,
    utf8t_unit_if.source unit_out,
    utf8t_cfg_if.sink    cfg
);

    // configuration
    logic strict_reg;
    logic rnull_reg;

    // input register
    logic       in_vld_reg, in_vld_next;
    logic [7:0] byte_reg;
    logic       last_reg;

    utf8t_pkg::dec_t dec;
    logic [1:0]      free;
    logic            advance;
    logic            in_take;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            strict_reg <= 1'b1;
            rnull_reg  <= 1'b0;
        end else if (cfg.valid) begin
            case (cfg.index)
                utf8t_pkg::CFG_STRICT_MODE: strict_reg <= cfg.data;
                utf8t_pkg::CFG_REJECT_NULL: rnull_reg  <= cfg.data;
                default: ;
            endcase
        end
    end

    // the held byte moves on once the result register has room for all it yields
    assign advance       = in_vld_reg && (dec.count <= free);
    assign byte_in.ready = !in_vld_reg || advance;
    assign in_take       = byte_in.valid && byte_in.ready;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_take)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take) begin
            byte_reg <= byte_in.in_byte;
            last_reg <= byte_in.in_last;
        end
    end

    utf8t_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .in_byte     (byte_reg),
        .in_last     (last_reg),
        .strict_mode (strict_reg),
        .reject_null (rnull_reg),
        .dec         (dec)
    );

    utf8t_out_queue u_out_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cnt (advance ? dec.count : 2'd0),
        .push0    (dec.res0),
        .push1    (dec.res1),
        .free     (free),
        .unit_out (unit_out)
    );

    a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !advance |=> in_vld_reg && $stable(byte_reg) && $stable(last_reg))
        else $error("held byte lost while blocked");

endmodule

### src/utf8t_decode.sv
module utf8t_decode (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    input  logic              strict_mode,
    input  logic              reject_null,
    output utf8t_pkg::dec_t   dec
);

    logic [utf8t_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [2:0]                  left_reg, left_next;
    logic [2:0]                  herr_reg, herr_next;
    logic                        emit;
    logic [utf8t_pkg::ACC_W-1:0] cp;
    logic [20:0]                 sub;
    logic [2:0]                  lead_cnt;
    logic [7:0]                  lead_mask;

    always_comb
    begin
        lead_cnt  = 3'd5;
        lead_mask = 8'h01;
        case (in_byte) inside
            [8'hC0:8'hDF]: begin lead_cnt = 3'd1; lead_mask = 8'h1F; end
            [8'hE0:8'hEF]: begin lead_cnt = 3'd2; lead_mask = 8'h0F; end
            [8'hF0:8'hF7]: begin lead_cnt = 3'd3; lead_mask = 8'h07; end
            [8'hF8:8'hFB]: begin lead_cnt = 3'd4; lead_mask = 8'h03; end
            default:       begin lead_cnt = 3'd5; lead_mask = 8'h01; end
        endcase
    end

    always_comb
    begin
        acc_next  = acc_reg;
        left_next = left_reg;
        herr_next = herr_reg;
        emit      = 1'b0;
        cp        = acc_reg;
        dec       = '0;

        if (left_reg == 3'd0) begin
            if (herr_reg == utf8t_pkg::ERR_NONE) begin
                if (in_byte == 8'd0 && reject_null) begin
                    herr_next = utf8t_pkg::ERR_NULL;
                end else if (in_byte < utf8t_pkg::BYTE_ASCII_END) begin
                    emit = 1'b1;
                    cp   = {23'd0, in_byte};
                end else if (in_byte < utf8t_pkg::BYTE_LEAD_MIN) begin
                    herr_next = utf8t_pkg::ERR_LEAD;
                end else begin
                    // oversize leads still count their trailing bytes
                    if (in_byte >= utf8t_pkg::BYTE_LEAD_BIG && in_byte != utf8t_pkg::BYTE_LEAD_FD)
                        herr_next = utf8t_pkg::ERR_LEAD;
                    acc_next  = {23'd0, in_byte & lead_mask};
                    left_next = lead_cnt;
                end
            end
        end else begin
            if (in_byte[7:6] != 2'b10)
                herr_next = utf8t_pkg::ERR_TRAIL;
            acc_next  = {acc_reg[utf8t_pkg::ACC_W-7:0], in_byte[5:0]};
            left_next = left_reg - 3'd1;
            if (left_next == 3'd0 && herr_next == utf8t_pkg::ERR_NONE) begin
                emit = 1'b1;
                cp   = acc_next;
            end
        end

        sub = cp[20:0] - utf8t_pkg::PLANE1_BASE;

        if (emit) begin
            if (cp <= utf8t_pkg::BMP_MAX) begin
                if (cp[15:0] >= utf8t_pkg::SURR_HI && cp[15:0] <= utf8t_pkg::SURR_END) begin
                    if (strict_mode) begin
                        herr_next = utf8t_pkg::ERR_ILLEG;
                    end else begin
                        dec.count = 2'd1;
                        dec.res0  = '{utf8t_pkg::REPL_CHAR, utf8t_pkg::ERR_NONE, in_last};
                    end
                end else begin
                    dec.count = 2'd1;
                    dec.res0  = '{cp[15:0], utf8t_pkg::ERR_NONE, in_last};
                end
            end else if (cp > utf8t_pkg::MAX_CODE) begin
                if (strict_mode) begin
                    herr_next = utf8t_pkg::ERR_ILLEG;
                end else begin
                    dec.count = 2'd1;
                    dec.res0  = '{utf8t_pkg::REPL_CHAR, utf8t_pkg::ERR_NONE, in_last};
                end
            end else begin
                // surrogate pair
                dec.count = 2'd2;
                dec.res0  = '{utf8t_pkg::SURR_HI + {6'd0, sub[19:10]},
                              utf8t_pkg::ERR_NONE, 1'b0};
                dec.res1  = '{utf8t_pkg::SURR_LO + (sub[15:0] & utf8t_pkg::TEN_MASK),
                              utf8t_pkg::ERR_NONE, in_last};
            end
        end

        // end of message: truncation wins, then any held error
        if (in_last) begin
            if (left_next != 3'd0) begin
                dec.count = 2'd1;
                dec.res0  = '{16'd0, utf8t_pkg::ERR_TRUNC, 1'b1};
            end else if (herr_next != utf8t_pkg::ERR_NONE) begin
                dec.count = 2'd1;
                dec.res0  = '{16'd0, herr_next, 1'b1};
            end
            acc_next  = '0;
            left_next = 3'd0;
            herr_next = utf8t_pkg::ERR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            acc_reg  <= '0;
            left_reg <= 3'd0;
            herr_reg <= utf8t_pkg::ERR_NONE;
        end else if (step) begin
            acc_reg  <= acc_next;
            left_reg <= left_next;
            herr_reg <= herr_next;
        end
    end

    a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= 3'd5)
        else $error("trailing byte count out of range");

    a_msg_clear: assert property (@(posedge clk) disable iff (!rst_n)
        step && in_last |=> left_reg == 3'd0 && herr_reg == utf8t_pkg::ERR_NONE)
        else $error("decode state not cleared at message end");

    a_pair_shape: assert property (@(posedge clk) disable iff (!rst_n)
        dec.count == 2'd2 |-> !dec.res0.out_last && dec.res0.error_kind == utf8t_pkg::ERR_NONE)
        else $error("bad surrogate pair result");

endmodule

### src/utf8t_out_queue.sv
module utf8t_out_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        push_cnt,
    input  utf8t_pkg::result_t push0,
    input  utf8t_pkg::result_t push1,
    output logic [1:0]        free,
    utf8t_unit_if.source      unit_out
);

    utf8t_pkg::result_t slot0_reg, slot0_next;
    utf8t_pkg::result_t slot1_reg, slot1_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic               pop;
    logic [1:0]         kept;
    utf8t_pkg::result_t head_kept;

    assign free = 2'd2 - cnt_reg;
    assign pop  = unit_out.valid && unit_out.ready;

    assign unit_out.valid      = cnt_reg != 2'd0;
    assign unit_out.code_unit  = slot0_reg.code_unit;
    assign unit_out.error_kind = slot0_reg.error_kind;
    assign unit_out.out_last   = slot0_reg.out_last;

    always_comb
    begin
        kept       = cnt_reg - {1'b0, pop};
        head_kept  = pop ? slot1_reg : slot0_reg;
        slot0_next = head_kept;
        slot1_next = slot1_reg;
        case (kept)
            2'd0:
            begin
                if (push_cnt != 2'd0)
                    slot0_next = push0;
                if (push_cnt == 2'd2)
                    slot1_next = push1;
            end
            2'd1:
            begin
                if (push_cnt != 2'd0)
                    slot1_next = push0;
            end
            default: ;
        endcase
        cnt_next = kept + push_cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push_cnt <= free)
        else $error("push exceeds free slots");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2)
        else $error("queue count out of range");

endmodule

### tb/sv/utf8_to_utf16_transcoder_top_test.sv
module utf8_to_utf16_transcoder_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Run limits.
    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned DRAIN_SETTLE    = 4;    // input reg + 2-entry result reg
    localparam int unsigned END_SETTLE      = 10;
    localparam int unsigned HOLD_OFF_CYCLES = 200;
    localparam int unsigned PRINT_CAP       = 100;
    localparam int unsigned PHASE_BYTES     = 150;

    // Byte classes not in the package
    localparam logic [7:0] LEAD_3B   = 8'hE0;
    localparam logic [7:0] LEAD_4B   = 8'hF0;
    localparam logic [7:0] LEAD_5B   = 8'hF8;
    localparam logic [7:0] TRAIL_MAX = 8'hBF;

    typedef enum int unsigned {SINK_ALWAYS, SINK_RANDOM, SINK_PERIODIC, SINK_SLOW} sink_mode_e;

    logic clk;
    logic rst_n;

    utf8t_byte_if byte_bus();
    utf8t_unit_if unit_bus();
    utf8t_cfg_if  cfg_bus();

    utf8_to_utf16_transcoder_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_in  (byte_bus),
        .unit_out (unit_bus),
        .cfg      (cfg_bus)
    );

    // ------------------------------------------------------------------
    // Decoder mirror: configuration copy, decode state, expected units
    // ------------------------------------------------------------------
    logic        strict_q;
    logic        reject_null_q;
    logic [30:0] cp_acc;        // code point being assembled
    logic [2:0]  trail_left;    // continuation bytes still owed
    logic [2:0]  held_kind;     // error held for the current message

    utf8t_pkg::result_t expected_units[$];

    // Traffic control shared between the test tasks and the sink process
    logic [7:0]  msg_bytes[$];
    int unsigned counted_bytes;     // bytes that were not merely dropped
    bit          gaps_on;
    int unsigned burst_left;
    sink_mode_e  sink_mode;
    int unsigned hold_off;          // sink stall request, counted down by the sink
    int unsigned mismatch_count;
    int unsigned cycle_count;

    function automatic void push_unit(logic [15:0] unit, logic [2:0] kind, logic last);
        utf8t_pkg::result_t r;
        r.code_unit  = unit;
        r.error_kind = kind;
        r.out_last   = last;
        expected_units.push_back(r);
    endfunction

    // A completed code point: BMP unit, surrogate pair, replacement, or a held
    // illegal-point error in strict mode.
    function automatic void emit_code_point(logic [30:0] cp, logic last);
        logic [20:0] offset;
        if (cp <= utf8t_pkg::BMP_MAX)
        begin
            if (cp[15:0] >= utf8t_pkg::SURR_HI && cp[15:0] <= utf8t_pkg::SURR_END)
            begin
                if (strict_q)
                    held_kind = utf8t_pkg::ERR_ILLEG;
                else
                    push_unit(utf8t_pkg::REPL_CHAR, utf8t_pkg::ERR_NONE, last);
            end
            else
                push_unit(cp[15:0], utf8t_pkg::ERR_NONE, last);
        end
        else if (cp > utf8t_pkg::MAX_CODE)
        begin
            if (strict_q)
                held_kind = utf8t_pkg::ERR_ILLEG;
            else
                push_unit(utf8t_pkg::REPL_CHAR, utf8t_pkg::ERR_NONE, last);
        end
        else
        begin
            offset = cp[20:0] - utf8t_pkg::PLANE1_BASE;
            push_unit(utf8t_pkg::SURR_HI + {6'd0, offset[19:10]}, utf8t_pkg::ERR_NONE, 1'b0);
            push_unit(utf8t_pkg::SURR_LO + {6'd0, offset[9:0]}, utf8t_pkg::ERR_NONE, last);
        end
    endfunction

    // Advance the mirror by one accepted byte. Returns 1 when the byte was
    // simply dropped (after an error, not the message end).
    function automatic bit decode_byte(logic [7:0] b, logic last);
        bit          dropped;
        logic [2:0]  n_trail;
        logic [7:0]  lead_mask;
        dropped = 1'b0;
        if (trail_left == 3'd0)
        begin
            if (held_kind != utf8t_pkg::ERR_NONE)
                dropped = !last;
            else if (b == 8'd0 && reject_null_q)
                held_kind = utf8t_pkg::ERR_NULL;
            else if (b < utf8t_pkg::BYTE_ASCII_END)
                emit_code_point({23'd0, b}, last);
            else if (b < utf8t_pkg::BYTE_LEAD_MIN)
                held_kind = utf8t_pkg::ERR_LEAD;
            else
            begin
                if (b < LEAD_3B)
                begin
                    n_trail = 3'd1; lead_mask = 8'h1F;
                end
                else if (b < LEAD_4B)
                begin
                    n_trail = 3'd2; lead_mask = 8'h0F;
                end
                else if (b < LEAD_5B)
                begin
                    n_trail = 3'd3; lead_mask = 8'h07;
                end
                else if (b < utf8t_pkg::BYTE_LEAD_BIG)
                begin
                    n_trail = 3'd4; lead_mask = 8'h03;
                end
                else
                begin
                    n_trail = 3'd5; lead_mask = 8'h01;
                end
                // oversize leads still consume their five continuation bytes
                if (b >= utf8t_pkg::BYTE_LEAD_BIG && b != utf8t_pkg::BYTE_LEAD_FD)
                    held_kind = utf8t_pkg::ERR_LEAD;
                cp_acc     = {23'd0, b & lead_mask};
                trail_left = n_trail;
            end
        end
        else
        begin
            if (b < utf8t_pkg::BYTE_ASCII_END || b > TRAIL_MAX)
                held_kind = utf8t_pkg::ERR_TRAIL;
            cp_acc     = {cp_acc[24:0], b[5:0]};
            trail_left = trail_left - 3'd1;
            if (trail_left == 3'd0 && held_kind == utf8t_pkg::ERR_NONE)
                emit_code_point(cp_acc, last);
        end
        if (last)
        begin
            // truncation wins over any held error
            if (trail_left != 3'd0)
                push_unit(16'd0, utf8t_pkg::ERR_TRUNC, 1'b1);
            else if (held_kind != utf8t_pkg::ERR_NONE)
                push_unit(16'd0, held_kind, 1'b1);
            cp_acc     = '0;
            trail_left = 3'd0;
            held_kind  = utf8t_pkg::ERR_NONE;
        end
        return dropped;
    endfunction

    task automatic report_mismatch(input string what);
        // stay quiet after the first hundred, keep counting
        if (mismatch_count < PRINT_CAP)
            $display("[%0t] MISMATCH %s", $realtime, what);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Clock, watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d units outstanding",
                 cycle_count, expected_units.size());
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sink side: ready pattern of its own, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : unit_sink
        int unsigned stall_phase;
        stall_phase    = 0;
        unit_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off != 0)
            begin
                unit_bus.ready <= 1'b0;
                hold_off--;
            end
            else
            begin
                case (sink_mode)
                    SINK_ALWAYS:   unit_bus.ready <= 1'b1;
                    SINK_RANDOM:   unit_bus.ready <= ($urandom_range(0, 3) != 0);
                    SINK_PERIODIC: unit_bus.ready <= (stall_phase >= 3);
                    default:       unit_bus.ready <= ($urandom_range(0, 3) == 0);
                endcase
                stall_phase = (stall_phase + 1) % 8;
            end
        end
    end

    // Every unit transaction is checked against the oldest expectation.
    always @(posedge clk)
    begin : unit_checker
        utf8t_pkg::result_t want;
        if (rst_n && unit_bus.valid && unit_bus.ready)
        begin
            if (expected_units.size() == 0)
                report_mismatch($sformatf("unexpected unit %h kind %0d last %b",
                                unit_bus.code_unit, unit_bus.error_kind,
                                unit_bus.out_last));
            else
            begin
                want = expected_units.pop_front();
                if (unit_bus.code_unit !== want.code_unit)
                    report_mismatch($sformatf("code_unit %h, want %h",
                                    unit_bus.code_unit, want.code_unit));
                if (unit_bus.error_kind !== want.error_kind)
                    report_mismatch($sformatf("error_kind %0d, want %0d",
                                    unit_bus.error_kind, want.error_kind));
                if (unit_bus.out_last !== want.out_last)
                    report_mismatch($sformatf("out_last %b, want %b",
                                    unit_bus.out_last, want.out_last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Source side. All tasks are entered just after a rising edge.
    // ------------------------------------------------------------------

    // One byte transaction; valid stays up on return so back-to-back bytes
    // never drop it. Bursts end in a random gap when gaps are enabled.
    task automatic send_byte(input logic [7:0] b, input logic last);
        byte_bus.valid   <= 1'b1;
        byte_bus.in_byte <= b;
        byte_bus.in_last <= last;
        do
            @(posedge clk);
        while (!byte_bus.ready);
        if (!decode_byte(b, last))
            counted_bytes++;
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                byte_bus.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst_left = $urandom_range(1, 16);
            end
            else
                burst_left--;
        end
    endtask

    task automatic send_message();
        int unsigned i;
        for (i = 0; i < msg_bytes.size(); i++)
            send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    endtask

    // Sender pause until every expected unit is back, then let the pipe empty.
    task automatic wait_drained();
        byte_bus.valid <= 1'b0;
        while (expected_units.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [utf8t_pkg::CFG_IDX_W-1:0] idx, input logic value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        if (idx == utf8t_pkg::CFG_STRICT_MODE)
            strict_q = value;
        else
            reject_null_q = value;
    endtask

    // Registers change only with the block idle.
    task automatic set_config(input logic strict, input logic reject_null);
        wait_drained();
        write_reg(utf8t_pkg::CFG_STRICT_MODE, strict);
        write_reg(utf8t_pkg::CFG_REJECT_NULL, reject_null);
        cfg_bus.valid <= 1'b0;
    endtask

    // Mostly well-formed messages with random content across all sequence
    // lengths; some are pure noise and some get one byte broken or cut off.
    task automatic build_message();
        int unsigned pick, n_chars, n_len, k, j;
        logic [30:0] v;
        logic [7:0]  lead_prefix, lead_mask;
        msg_bytes.delete();
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            n_chars = $urandom_range(1, 6);
            for (k = 0; k < n_chars; k++)
                msg_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        n_chars = $urandom_range(1, 6);
        for (k = 0; k < n_chars; k++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: n_len = 1;
                3, 4:    n_len = 2;
                5, 6:    n_len = 3;
                7, 8:    n_len = 4;
                default: n_len = $urandom_range(5, 6);
            endcase
            lead_prefix = 8'h00;
            lead_mask   = 8'h7F;
            case (n_len)
                1:
                begin
                    v = ($urandom_range(0, 7) == 0) ? 31'd0 : 31'($urandom_range(0, 'h7F));
                end
                2:
                begin
                    v = 31'($urandom_range(0, 'h7FF));
                    lead_prefix = 8'hC0; lead_mask = 8'h1F;
                end
                3:
                begin
                    case ($urandom_range(0, 5))
                        0:       v = 31'h0000_FFFF;
                        1, 2:    v = 31'($urandom_range('hD800, 'hDFFF));
                        default: v = 31'($urandom_range(0, 'hFFFF));
                    endcase
                    lead_prefix = LEAD_3B; lead_mask = 8'h0F;
                end
                4:
                begin
                    case ($urandom_range(0, 9))
                        0:       v = 31'h0010_FFFF;
                        1:       v = 31'h0011_0000;
                        2:       v = 31'h0001_0000;
                        3, 4:    v = 31'($urandom_range(0, 'h1FFFFF));
                        default: v = 31'($urandom_range('h10000, 'h10FFFF));
                    endcase
                    lead_prefix = LEAD_4B; lead_mask = 8'h07;
                end
                5:
                begin
                    v = 31'($urandom_range(0, 'h3FFFFFF));
                    lead_prefix = LEAD_5B; lead_mask = 8'h03;
                end
                default:
                begin
                    v = 31'($urandom);
                    lead_prefix = utf8t_pkg::BYTE_LEAD_BIG; lead_mask = 8'h01;
                end
            endcase
            if (n_len == 1)
                msg_bytes.push_back(v[7:0]);
            else
            begin
                msg_bytes.push_back(lead_prefix | (8'(v >> (6 * (n_len - 1))) & lead_mask));
                for (j = n_len - 1; j > 0; j--)
                    msg_bytes.push_back(8'h80 | (8'(v >> (6 * (j - 1))) & 8'h3F));
            end
        end
        if (pick < 25)
        begin
            j = $urandom_range(0, msg_bytes.size() - 1);
            case ($urandom_range(0, 2))
                0:       msg_bytes[j] = 8'($urandom_range(0, 255));
                1:       msg_bytes[j] = 8'($urandom_range(8'h80, TRAIL_MAX));
                default: if (msg_bytes.size() > 1) void'(msg_bytes.pop_back());
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset config (strict, zero allowed): zero and 0x7F as single bytes,
    // a two-byte char and a supplementary char split into a surrogate pair.
    task automatic test_basic_decode();
        msg_bytes = '{8'h00, 8'h7F, 8'hC2, 8'hA9, 8'hF0, 8'h9F, 8'h98, 8'h80};
        send_message();
    endtask

    // Error messages under strict mode: lead, truncation, trailing, illegal, oversize lead.
    task automatic test_error_kinds();
        // stray continuation as a lead; 0xFF after it only closes the message
        msg_bytes = '{utf8t_pkg::BYTE_ASCII_END, 8'hFF};
        send_message();
        // bad trailing byte, then the message ends mid-sequence: truncated
        msg_bytes = '{LEAD_3B | 8'h02, 8'h41};
        send_message();
        // bad trailing byte with the sequence run to its end
        msg_bytes = '{LEAD_3B | 8'h02, 8'h41, 8'h82};
        send_message();
        // encoded surrogate is illegal in strict mode
        msg_bytes = '{8'hED, 8'hA0, 8'h80};
        send_message();
        // oversize lead counts its five continuation bytes, then reports
        msg_bytes = '{utf8t_pkg::BYTE_LEAD_BIG, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80};
        send_message();
    endtask

    // Relaxed mode with zero rejection: null error, surrogate replaced.
    task automatic test_config_modes();
        set_config(1'b0, 1'b1);
        msg_bytes = '{8'h00};
        send_message();
        msg_bytes = '{8'hED, 8'hBF, 8'hBF};
        send_message();
    endtask

    // Sink holds off for a long stretch while the source keeps offering
    // surrogate-pair traffic, so the result register fills and byte_in stalls.
    task automatic test_backpressure();
        int unsigned k;
        set_config(1'b1, 1'b0);
        gaps_on   = 1'b0;
        sink_mode = SINK_ALWAYS;
        hold_off  = HOLD_OFF_CYCLES;
        for (k = 0; k < 8; k++)
        begin
            msg_bytes = '{LEAD_4B, 8'h9F, 8'h98, 8'h80 | 8'(k), 8'h41};
            send_message();
        end
        wait_drained();
    endtask

    // Random messages over all four register settings, with changing sink
    // patterns, sender gaps on and off, and occasional full drains.
    task automatic test_random_traffic();
        int unsigned phase;
        int unsigned target;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       set_config(1'b1, 1'b1);
                1:       set_config(1'b0, 1'b0);
                2:       set_config(1'b0, 1'b1);
                default: set_config(1'b1, 1'b0);
            endcase
            target = counted_bytes + PHASE_BYTES;
            while (counted_bytes < target)
            begin
                if ($urandom_range(0, 7) == 0)
                    gaps_on = !gaps_on;
                if ($urandom_range(0, 5) == 0)
                    sink_mode = sink_mode_e'($urandom_range(0, 3));
                if ($urandom_range(0, 19) == 0)
                    wait_drained();
                build_message();
                send_message();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n            = 1'b0;
        byte_bus.valid   = 1'b0;
        byte_bus.in_byte = 8'd0;
        byte_bus.in_last = 1'b0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.index    = utf8t_pkg::CFG_STRICT_MODE;
        cfg_bus.data     = 1'b0;

        // mirror starts from the reset values
        strict_q       = 1'b1;
        reject_null_q  = 1'b0;
        cp_acc         = '0;
        trail_left     = 3'd0;
        held_kind      = utf8t_pkg::ERR_NONE;
        counted_bytes  = 0;
        mismatch_count = 0;
        hold_off       = 0;
        gaps_on        = 1'b1;
        burst_left     = 4;
        sink_mode      = SINK_RANDOM;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_decode();
        test_error_kinds();
        test_config_modes();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (END_SETTLE) @(posedge clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
